>>> hw/rtl/assert_macros.svh
// Shared assertion macros for the pool allocator checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

>>> hw/rtl/fbpa_pkg.sv
package fbpa_pkg;

    localparam int SLOTS         = 1024;
    localparam int SLOT_W        = 10;
    localparam int SIZE_W        = 13;
    localparam int ADDR_W        = 32;
    localparam int CAP_W         = 11;
    localparam int PROD_W        = SLOT_W + SIZE_W;
    localparam int POINTER_BYTES = 8;
    localparam int ALIGN_BYTES   = 16;
    localparam int MAX_REQUEST   = 4096;

    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

    localparam int CFG_IDX_W     = 2;
    localparam int CFG_W         = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_REQUEST_BYTES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_BASE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY      = 2'd2;

    localparam logic [SIZE_W-1:0] RESET_REQUEST  = 13'd8;
    localparam logic [CAP_W-1:0]  RESET_CAPACITY = 11'd1024;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef enum logic [1:0] {
        OP_ALLOC,
        OP_FREE,
        OP_IGNORE
    } op_kind_t;

    typedef struct packed {
        op_kind_t            kind;
        logic [SLOT_W-1:0]   slot;
    } op_t;

    typedef struct packed {
        logic [SIZE_W-1:0]   block_bytes;
        logic [ADDR_W-1:0]   region_base;
        logic [CAP_W-1:0]    cap;
    } cfg_t;

    // Clamp to the request ceiling, raise to pointer size, then round non-powers of two up to the alignment.
    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] req);
        logic [SIZE_W-1:0] s;
        s = req;
        if (s > SIZE_W'(MAX_REQUEST))
            s = SIZE_W'(MAX_REQUEST);
        if (s < SIZE_W'(POINTER_BYTES))
            s = SIZE_W'(POINTER_BYTES);
        if ((s & (s - SIZE_W'(1))) != '0)
            s = (s + SIZE_W'(ALIGN_BYTES - 1)) & ~SIZE_W'(ALIGN_BYTES - 1);
        return s;
    endfunction

endpackage

>>> hw/rtl/fbpa_channels.sv
interface fbpa_req_if;
    logic                          valid;
    logic                          ready;
    logic                          cmd;
    logic [fbpa_pkg::SLOT_W-1:0]   free_slot;
    logic                          free_null;

    modport source (output valid, cmd, free_slot, free_null, input ready);
    modport sink   (input valid, cmd, free_slot, free_null, output ready);
endinterface

interface fbpa_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          ok;
    logic [fbpa_pkg::SLOT_W-1:0]   slot;
    logic [fbpa_pkg::ADDR_W-1:0]   address;
    logic [fbpa_pkg::SIZE_W-1:0]   block_bytes;

    modport source (output valid, ok, slot, address, block_bytes, input ready);
    modport sink   (input valid, ok, slot, address, block_bytes, output ready);
endinterface

>>> hw/rtl/fixed_block_pool_allocator_top.sv
// Fixed-size block pool allocator.
// Requests arrive on the req channel (cmd, free_slot, free_null) and each
// one produces exactly one beat on the rsp channel (ok, slot, address,
// block_bytes), in request order. Both channels move a beat when valid and
// ready are high at a rising clock edge.
// Configuration registers (request size, region base, capacity) are written
// through cfg_we/cfg_index/cfg_wdata; the user must write them only while
// no request is in flight, which the block itself does not enforce. A
// two-entry queue decouples request intake from execution, so requests
// are taken while the back end works or waits on a stalled receiver.
// The back end takes one request at a time and accepts the next only once
// the previous one has reached the output register. Its sequence is the
// link memory read (for an allocation that pops the free list), one
// multiplier stage and the address add into the output register.
// When rsp.ready is low the response holds and the queue fills; req.ready
// drops once the queue is full. Reset empties the free list and the queue,
// clears the fresh-slot counter and restores the register defaults. The
// link memory needs no clearing pass.
module fixed_block_pool_allocator_top
(
    input  logic                                clk,
    input  logic                                rst_n,
    fbpa_req_if.sink                            req,
    fbpa_rsp_if.source                          rsp,
    input  logic                                cfg_we,
    input  logic [fbpa_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [fbpa_pkg::CFG_W-1:0]          cfg_wdata
);

    fbpa_pkg::cfg_t                 cfg_reg;
    logic                           push_valid;
    logic                           push_ready;
    fbpa_pkg::op_t                  push_op;
    logic                           pop_valid;
    logic                           pop_ready;
    fbpa_pkg::op_t                  pop_op;
    logic [fbpa_pkg::CAP_W-1:0]     cap_wr;

    assign cap_wr = cfg_wdata[fbpa_pkg::CAP_W-1:0];

    // The effective block size is worked out once, when the request size is written.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.block_bytes <= fbpa_pkg::eff_size(fbpa_pkg::RESET_REQUEST);
            cfg_reg.region_base <= '0;
            cfg_reg.cap         <= fbpa_pkg::RESET_CAPACITY;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                fbpa_pkg::CFG_REQUEST_BYTES:
                    cfg_reg.block_bytes <=
                        fbpa_pkg::eff_size(cfg_wdata[fbpa_pkg::SIZE_W-1:0]);
                fbpa_pkg::CFG_REGION_BASE:
                    cfg_reg.region_base <= cfg_wdata[fbpa_pkg::ADDR_W-1:0];
                fbpa_pkg::CFG_CAPACITY:
                    cfg_reg.cap <= (cap_wr > fbpa_pkg::CAP_W'(fbpa_pkg::SLOTS)) ?
                                   fbpa_pkg::CAP_W'(fbpa_pkg::SLOTS) : cap_wr;
                default:
                begin
                end
            endcase
        end
    end

    fbpa_front u_front
    (
        .req        (req),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_op    (push_op)
    );

    fbpa_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_op    (push_op),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_op     (pop_op)
    );

    fbpa_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_op     (pop_op),
        .rsp        (rsp)
    );

endmodule

>>> hw/rtl/fbpa_front.sv
module fbpa_front
(
    fbpa_req_if.sink         req,
    output logic             push_valid,
    input  logic             push_ready,
    output fbpa_pkg::op_t    push_op
);

    assign push_valid = req.valid;
    assign req.ready  = push_ready;

    // Null frees and out-of-range slots turn into a no-op that still answers.
    always_comb
    begin
        push_op.slot = req.free_slot;
        if (req.cmd == fbpa_pkg::CMD_ALLOC)
            push_op.kind = fbpa_pkg::OP_ALLOC;
        else if (req.free_null ||
                 ({1'b0, req.free_slot} >= (fbpa_pkg::SLOT_W + 1)'(fbpa_pkg::SLOTS)))
            push_op.kind = fbpa_pkg::OP_IGNORE;
        else
            push_op.kind = fbpa_pkg::OP_FREE;
    end

endmodule

>>> hw/rtl/fbpa_queue.sv
module fbpa_queue
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  fbpa_pkg::op_t    push_op,
    output logic             pop_valid,
    input  logic             pop_ready,
    output fbpa_pkg::op_t    pop_op
);

    fbpa_pkg::op_t                    entry_reg [fbpa_pkg::QUEUE_DEPTH];
    logic [fbpa_pkg::QPTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [fbpa_pkg::QPTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [fbpa_pkg::QCNT_W-1:0]      count_reg, count_next;
    logic                             do_push;
    logic                             do_pop;

    assign push_ready = (count_reg != fbpa_pkg::QCNT_W'(fbpa_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_op     = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == fbpa_pkg::QPTR_W'(fbpa_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == fbpa_pkg::QPTR_W'(fbpa_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (!do_push && do_pop)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_op;
    end

endmodule

>>> hw/rtl/fbpa_back.sv
module fbpa_back
(
    input  logic             clk,
    input  logic             rst_n,
    input  fbpa_pkg::cfg_t   cfg,
    input  logic             pop_valid,
    output logic             pop_ready,
    input  fbpa_pkg::op_t    pop_op,
    fbpa_rsp_if.source       rsp
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_MUL,
        S_ADD
    } state_t;

    state_t                             state_reg;
    logic [fbpa_pkg::SLOT_W-1:0]        head_reg;
    logic                               nonempty_reg;
    logic [fbpa_pkg::CAP_W-1:0]         fresh_reg;
    logic                               ok_reg;
    logic [fbpa_pkg::SLOT_W-1:0]        slot_reg;
    logic [fbpa_pkg::PROD_W-1:0]        prod_reg;
    logic                               out_valid_reg;
    logic                               out_ok_reg;
    logic [fbpa_pkg::SLOT_W-1:0]        out_slot_reg;
    logic [fbpa_pkg::ADDR_W-1:0]        out_addr_reg;
    logic [fbpa_pkg::SIZE_W-1:0]        out_size_reg;

    // Each link entry holds the next slot and whether a further element follows.
    logic [fbpa_pkg::SLOT_W:0]          link_mem [fbpa_pkg::SLOTS];
    logic [fbpa_pkg::SLOT_W:0]          link_rd_reg;
    logic                               mem_we;
    logic                               out_free;

    assign pop_ready = (state_reg == S_IDLE);
    assign mem_we    = (state_reg == S_IDLE) && pop_valid && (pop_op.kind == fbpa_pkg::OP_FREE);
    assign out_free  = !out_valid_reg || rsp.ready;

    assign rsp.valid       = out_valid_reg;
    assign rsp.ok          = out_ok_reg;
    assign rsp.slot        = out_slot_reg;
    assign rsp.address     = out_addr_reg;
    assign rsp.block_bytes = out_size_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            link_mem[pop_op.slot] <= {nonempty_reg, head_reg};
        link_rd_reg <= link_mem[head_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            nonempty_reg  <= 1'b0;
            fresh_reg     <= '0;
            ok_reg        <= 1'b0;
            slot_reg      <= '0;
            prod_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_ok_reg    <= 1'b0;
            out_slot_reg  <= '0;
            out_addr_reg  <= '0;
            out_size_reg  <= '0;
        end
        else
        begin
            // In S_ADD the output register is reloaded as soon as it frees up.
            if (out_valid_reg && rsp.ready && (state_reg != S_ADD))
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (pop_valid)
                    begin
                        unique case (pop_op.kind)
                            fbpa_pkg::OP_ALLOC:
                            begin
                                if (nonempty_reg)
                                begin
                                    // The link of the head arrives from memory next cycle.
                                    ok_reg    <= 1'b1;
                                    slot_reg  <= head_reg;
                                    state_reg <= S_READ;
                                end
                                else if (fresh_reg < cfg.cap)
                                begin
                                    ok_reg    <= 1'b1;
                                    slot_reg  <= fresh_reg[fbpa_pkg::SLOT_W-1:0];
                                    fresh_reg <= fresh_reg + 1'b1;
                                    state_reg <= S_MUL;
                                end
                                else
                                begin
                                    ok_reg    <= 1'b0;
                                    slot_reg  <= '0;
                                    state_reg <= S_MUL;
                                end
                            end
                            fbpa_pkg::OP_FREE:
                            begin
                                ok_reg       <= 1'b1;
                                slot_reg     <= pop_op.slot;
                                head_reg     <= pop_op.slot;
                                nonempty_reg <= 1'b1;
                                state_reg    <= S_MUL;
                            end
                            default:
                            begin
                                ok_reg    <= 1'b0;
                                slot_reg  <= '0;
                                state_reg <= S_MUL;
                            end
                        endcase
                    end
                end
                S_READ:
                begin
                    head_reg     <= link_rd_reg[fbpa_pkg::SLOT_W-1:0];
                    nonempty_reg <= link_rd_reg[fbpa_pkg::SLOT_W];
                    state_reg    <= S_MUL;
                end
                S_MUL:
                begin
                    prod_reg  <= fbpa_pkg::PROD_W'(slot_reg) * fbpa_pkg::PROD_W'(cfg.block_bytes);
                    state_reg <= S_ADD;
                end
                S_ADD:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_ok_reg    <= ok_reg;
                        out_slot_reg  <= slot_reg;
                        out_addr_reg  <= ok_reg ?
                                         cfg.region_base + fbpa_pkg::ADDR_W'(prod_reg) : '0;
                        out_size_reg  <= cfg.block_bytes;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

>>> hw/rtl/fbpa_checker.sv
`include "assert_macros.svh"

module fbpa_checker
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               rsp_valid,
    input  logic                               rsp_ready,
    input  logic                               rsp_ok,
    input  logic [fbpa_pkg::SLOT_W-1:0]        rsp_slot,
    input  logic [fbpa_pkg::ADDR_W-1:0]        rsp_address,
    input  logic [fbpa_pkg::SIZE_W-1:0]        rsp_block_bytes
);

    logic rsp_stall;
    logic fields_zero;
    logic size_in_range;

    assign rsp_stall     = rsp_valid && !rsp_ready;
    assign fields_zero   = (rsp_slot == '0) && (rsp_address == '0);
    assign size_in_range = (rsp_block_bytes >= fbpa_pkg::SIZE_W'(fbpa_pkg::POINTER_BYTES)) &&
                           (rsp_block_bytes <= fbpa_pkg::SIZE_W'(fbpa_pkg::MAX_REQUEST));

    // A stalled response beat stays up with its slot and address unchanged.
    `ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_stall, rsp_valid)
    `ASSERT_NEXT(a_rsp_stable, clk, rst_n, rsp_stall, $stable(rsp_slot) && $stable(rsp_address))

    // A refused request reports neither a slot nor an address.
    `ASSERT_IMPLIES(a_fail_zero, clk, rst_n, rsp_valid && !rsp_ok, fields_zero)

    // The rounded block size stays within pointer size and the request ceiling.
    `ASSERT_IMPLIES(a_size_range, clk, rst_n, rsp_valid, size_in_range)

endmodule

bind fixed_block_pool_allocator_top fbpa_checker u_fbpa_checker
(
    .clk             (clk),
    .rst_n           (rst_n),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_ok          (rsp.ok),
    .rsp_slot        (rsp.slot),
    .rsp_address     (rsp.address),
    .rsp_block_bytes (rsp.block_bytes)
);

>>> tb/fbpa_pool_checker.sv
`timescale 1ns / 100ps

module fbpa_pool_checker
    import fbpa_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    fbpa_req_if                  req,
    fbpa_rsp_if                  rsp,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    output int                   mismatches,
    output int                   pending
);

    typedef struct packed {
        logic              ok;
        logic [SLOT_W-1:0] slot;
        logic [ADDR_W-1:0] address;
        logic [SIZE_W-1:0] block_bytes;
    } grant_t;

    logic [SIZE_W-1:0] request_bytes_q;
    logic [ADDR_W-1:0] base_q;
    logic [CAP_W-1:0]  capacity_q;

    logic [SLOT_W-1:0] head;
    logic              head_valid;
    logic [SLOT_W-1:0] link [SLOTS];
    logic              link_valid [SLOTS];
    logic [CAP_W-1:0]  fresh_count;

    grant_t grants_due[$];

    task automatic report_mismatch(input string what);
        if (mismatches < 100)
            $display("%0t pool check: %s", $time, what);
        mismatches++;
    endtask

    function automatic logic [SIZE_W-1:0] rounded_block_bytes(input logic [SIZE_W-1:0] requested);
        int unsigned s;
        s = requested;
        if (s > MAX_REQUEST)
            s = MAX_REQUEST;
        if (s < POINTER_BYTES)
            s = POINTER_BYTES;
        if ((s & (s - 1)) != 0)
            s = ((s + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
        return SIZE_W'(s);
    endfunction

    // Pops the free list first, then bumps the fresh counter; a non-null free pushes its slot.
    function automatic grant_t serve_request(input logic cmd, input logic [SLOT_W-1:0] fslot,
                                             input logic fnull);
        grant_t            g;
        logic [SIZE_W-1:0] bytes;
        logic [CAP_W-1:0]  limit;
        bytes = rounded_block_bytes(request_bytes_q);
        limit = (capacity_q > SLOTS) ? CAP_W'(SLOTS) : capacity_q;
        g = '0;
        g.block_bytes = bytes;
        if (cmd == CMD_ALLOC) begin
            if (head_valid) begin
                g.ok = 1'b1;
                g.slot = head;
                head_valid = link_valid[head];
                head = link[head];
            end
            else if (fresh_count < limit) begin
                g.ok = 1'b1;
                g.slot = fresh_count[SLOT_W-1:0];
                fresh_count = fresh_count + 1'b1;
            end
        end
        else if (!fnull) begin
            link[fslot] = head;
            link_valid[fslot] = head_valid;
            head = fslot;
            head_valid = 1'b1;
            g.ok = 1'b1;
            g.slot = fslot;
        end
        if (g.ok)
            g.address = base_q + ADDR_W'(g.slot) * ADDR_W'(bytes);
        return g;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        grant_t want;
        if (!rst_n) begin
            request_bytes_q = RESET_REQUEST;
            base_q = '0;
            capacity_q = RESET_CAPACITY;
            head = '0;
            head_valid = 1'b0;
            fresh_count = '0;
            grants_due.delete();
            pending = 0;
            mismatches = 0;
        end
        else begin
            if (rsp.valid && rsp.ready) begin
                if (grants_due.size() == 0)
                    report_mismatch("response beat with no request waiting");
                else begin
                    want = grants_due.pop_front();
                    if (rsp.ok !== want.ok)
                        report_mismatch($sformatf("ok %b, want %b", rsp.ok, want.ok));
                    if (rsp.slot !== want.slot)
                        report_mismatch($sformatf("slot %0d, want %0d", rsp.slot, want.slot));
                    if (rsp.address !== want.address)
                        report_mismatch($sformatf("address %h, want %h",
                                                  rsp.address, want.address));
                    if (rsp.block_bytes !== want.block_bytes)
                        report_mismatch($sformatf("block_bytes %0d, want %0d",
                                                  rsp.block_bytes, want.block_bytes));
                end
            end
            if (req.valid && req.ready)
                grants_due.push_back(serve_request(req.cmd, req.free_slot, req.free_null));
            if (cfg_we) begin
                case (cfg_index)
                    CFG_REQUEST_BYTES: request_bytes_q = cfg_wdata[SIZE_W-1:0];
                    CFG_REGION_BASE:   base_q = cfg_wdata[ADDR_W-1:0];
                    CFG_CAPACITY:      capacity_q = cfg_wdata[CAP_W-1:0];
                    default: ;
                endcase
            end
            pending = grants_due.size();
        end
    end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import fbpa_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int HOLD_CYCLES     = 400;
    localparam int STALL_LIMIT     = 3000;
    localparam int SETTLE_CYCLES   = 12;
    localparam int ITEMS_PER_PHASE = 125;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;

    int mismatches;
    int pending;
    int send_idle_pct;
    int recv_idle_pct;
    int quiet_cycles;
    bit hold_pending;

    fbpa_req_if req_ch();
    fbpa_rsp_if rsp_ch();

    fixed_block_pool_allocator_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    fbpa_pool_checker pool_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_ch),
        .rsp        (rsp_ch),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Any beat on either channel counts as progress.
    always @(posedge clk) begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Receiver: random stalls, plus one long hold-off on request.
    initial begin
        rsp_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            if (hold_pending) begin
                hold_pending = 1'b0;
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
                rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic apply_config(input logic [SIZE_W-1:0] bytes, input logic [ADDR_W-1:0] base,
                                input logic [CAP_W-1:0] cap);
        cfg_we <= 1'b1;
        cfg_index <= CFG_REQUEST_BYTES;
        cfg_wdata <= CFG_W'(bytes);
        @(posedge clk);
        cfg_index <= CFG_REGION_BASE;
        cfg_wdata <= base;
        @(posedge clk);
        cfg_index <= CFG_CAPACITY;
        cfg_wdata <= CFG_W'(cap);
        @(posedge clk);
        cfg_index <= CFG_UNUSED;
        cfg_wdata <= $urandom;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Valid stays high from one beat to the next unless a gap is drawn.
    task automatic send_beat(input logic cmd, input logic [SLOT_W-1:0] slot, input logic nul);
        if ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        req_ch.valid <= 1'b1;
        req_ch.cmd <= cmd;
        req_ch.free_slot <= slot;
        req_ch.free_null <= nul;
        do
            @(posedge clk);
        while (!req_ch.ready);
    endtask

    task automatic settle();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Frees mostly target low slots, which are the ones handed out, so the
    // list grows long chains and pops dominate.
    task automatic run_phase(input int alloc_pct, input int hold_at);
        int pick;
        for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (n == hold_at)
                hold_pending = 1'b1;
            pick = $urandom_range(99);
            if (pick < alloc_pct)
                send_beat(CMD_ALLOC, SLOT_W'($urandom), 1'($urandom));
            else if (pick < alloc_pct + 6)
                send_beat(CMD_FREE, SLOT_W'($urandom), 1'b1);
            else if ($urandom_range(3) != 0)
                send_beat(CMD_FREE, SLOT_W'($urandom_range(47)), 1'b0);
            else
                send_beat(CMD_FREE, SLOT_W'($urandom_range(SLOTS - 1)), 1'b0);
        end
    endtask

    initial begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        req_ch.valid = 1'b0;
        req_ch.cmd = CMD_ALLOC;
        req_ch.free_slot = '0;
        req_ch.free_null = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zero request size, a base that wraps, and a capacity of three.
        apply_config(13'd0, 32'hFFFF_FFF0, 11'd3);
        send_beat(CMD_ALLOC, '0, 1'b0);
        send_beat(CMD_ALLOC, 10'h3FF, 1'b1);
        send_beat(CMD_ALLOC, '0, 1'b0);
        send_beat(CMD_ALLOC, '0, 1'b0);
        send_beat(CMD_FREE, 10'h3FF, 1'b1);
        send_beat(CMD_FREE, 10'd1, 1'b0);
        send_beat(CMD_FREE, 10'h3FF, 1'b0);
        send_beat(CMD_FREE, 10'h3FF, 1'b0);
        send_beat(CMD_ALLOC, '0, 1'b0);
        send_beat(CMD_ALLOC, 10'h2AA, 1'b1);
        send_beat(CMD_ALLOC, '0, 1'b0);
        send_beat(CMD_ALLOC, '0, 1'b0);
        send_beat(CMD_FREE, 10'd0, 1'b0);
        send_beat(CMD_ALLOC, '0, 1'b0);
        send_beat(CMD_FREE, 10'd2, 1'b0);
        send_beat(CMD_FREE, 10'd0, 1'b0);
        settle();

        send_idle_pct = 25;
        recv_idle_pct = 58;
        apply_config(13'd4097, 32'h0000_0000, 11'd2047);
        run_phase(60, 40);
        settle();
        apply_config(13'd9, $urandom, 11'd1025);
        run_phase(50, -1);
        settle();

        send_idle_pct = 58;
        recv_idle_pct = 25;
        apply_config(13'd8191, 32'hFFFF_FFFF, 11'd0);
        run_phase(45, -1);
        settle();
        apply_config(13'd100, $urandom, 11'd1024);
        run_phase(55, 70);
        settle();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        apply_config(13'd1, $urandom, 11'd1);
        run_phase(50, -1);
        settle();
        apply_config(13'd24, 32'h8000_0000, 11'd1024);
        run_phase(55, -1);
        settle();

        if (mismatches == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
